// File: src/sgc_pkg.sv
// Shared types, register codes and color constants for the step-grid LED compositor.
// Used by every file in src; depends on nothing.
package sgc_pkg;

    // Grid geometry.
    localparam int GRID_COLUMNS = 16;
    localparam int GRID_ROWS    = 4;

    localparam int ROW_W   = 2;
    localparam int COL_W   = 4;
    localparam int VEL_W   = 7;
    localparam int CHAN_W  = 8;
    localparam int INDEX_W = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SELECTED_VOICE    = 3'd0,
        REG_CURSOR_COLUMN     = 3'd1,
        REG_PLAYHEAD_COLUMN   = 3'd2,
        REG_TRANSPORT_RUNNING = 3'd3,
        REG_MUTE_MASK         = 3'd4,
        REG_SOLO_MASK         = 3'd5,
        REG_SERPENTINE_ORDER  = 3'd6,
        REG_SINGLE_ROW_STRIP  = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic [ROW_W-1:0] selected_voice;
        logic [COL_W-1:0] cursor_column;
        logic [COL_W-1:0] playhead_column;
        logic             transport_running;
        logic [3:0]       mute_mask;
        logic [3:0]       solo_mask;
        logic             serpentine_order;
        logic             single_row_strip;
    } cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0] voice_row;
        logic [COL_W-1:0] step_column;
        logic             step_active;
        logic [VEL_W-1:0] velocity;
        logic             accent;
    } cell_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic               keep;
        logic [INDEX_W-1:0] pixel_index;
    } place_t;

    typedef struct packed {
        logic [INDEX_W-1:0] pixel_index;
        rgb_t               color;
    } pixel_t;

    // Brightness levels and overlay amounts.
    localparam logic [VEL_W-1:0]  VEL_FLOOR    = 7'd24;
    localparam logic [VEL_W-1:0]  GHOST_LEVEL  = 7'd16;
    localparam logic [VEL_W-1:0]  TINT_LEVEL   = 7'd12;
    localparam logic [CHAN_W-1:0] BEAT_LEVEL   = 8'd2;
    localparam logic [CHAN_W-1:0] ACCENT_ADD   = 8'd40;
    localparam logic [CHAN_W-1:0] CURSOR_ADD   = 8'd90;
    localparam logic [CHAN_W-1:0] PLAYHEAD_ADD = 8'd60;
    localparam logic [COL_W-1:0]  BEAT_MASK    = 4'd3;

    // Scaling: channel = base * level * BRIGHTNESS / (127 * 255), truncated.
    // The division is a multiply by a rounded-up reciprocal and a shift; with
    // levels below 128 the error stays under one step of the denominator.
    localparam longint unsigned BRIGHTNESS = 60;
    localparam longint unsigned DIM_DEN    = 127 * 255;
    localparam int              DIM_SHIFT  = 24;
    localparam int              COEF_W     = 23;
    localparam int              PROD_W     = COEF_W + VEL_W;

    localparam logic [COEF_W-1:0] COEF_255 = COEF_W'(
        (64'd255 * BRIGHTNESS * (64'd1 << DIM_SHIFT) + DIM_DEN - 64'd1) / DIM_DEN);
    localparam logic [COEF_W-1:0] COEF_140 = COEF_W'(
        (64'd140 * BRIGHTNESS * (64'd1 << DIM_SHIFT) + DIM_DEN - 64'd1) / DIM_DEN);
    localparam logic [COEF_W-1:0] COEF_80 = COEF_W'(
        (64'd80 * BRIGHTNESS * (64'd1 << DIM_SHIFT) + DIM_DEN - 64'd1) / DIM_DEN);
    localparam logic [COEF_W-1:0] COEF_0 = '0;

    // Per-voice base colors, already turned into scaling coefficients:
    // red, orange, green, blue.
    localparam logic [COEF_W-1:0] DIM_COEF [4][3] = '{
        '{COEF_255, COEF_0,   COEF_0  },
        '{COEF_255, COEF_140, COEF_0  },
        '{COEF_0,   COEF_255, COEF_0  },
        '{COEF_0,   COEF_80,  COEF_255}
    };

endpackage

// File: src/sgc_ifs.sv
// Valid/ready channel interfaces for grid cells in and LED pixels out.
// Depends on sgc_pkg for field widths.
interface sgc_cell_if;
    logic                            valid;
    logic                            ready;
    logic [sgc_pkg::ROW_W-1:0]       voice_row;
    logic [sgc_pkg::COL_W-1:0]       step_column;
    logic                            step_active;
    logic [sgc_pkg::VEL_W-1:0]       velocity;
    logic                            accent;

    modport source (output valid, voice_row, step_column, step_active, velocity, accent,
                    input ready);
    modport sink   (input valid, voice_row, step_column, step_active, velocity, accent,
                    output ready);
    modport mon    (input valid, ready, voice_row, step_column, step_active, velocity,
                    accent);
endinterface

interface sgc_pixel_if;
    logic                            valid;
    logic                            ready;
    logic [sgc_pkg::INDEX_W-1:0]     pixel_index;
    logic [sgc_pkg::CHAN_W-1:0]      red;
    logic [sgc_pkg::CHAN_W-1:0]      green;
    logic [sgc_pkg::CHAN_W-1:0]      blue;

    modport source (output valid, pixel_index, red, green, blue, input ready);
    modport sink   (input valid, pixel_index, red, green, blue, output ready);
    modport mon    (input valid, ready, pixel_index, red, green, blue);
endinterface

// File: src/step_grid_led_color_compositor.sv
// Top level of the step-grid LED color compositor: input register, color and
// placement logic, result register. Depends on sgc_pkg, sgc_ifs, sgc_cfg_regs,
// sgc_place and sgc_shade.
//
//   Channel   Direction  Carries                                   Handshake
//   cells     in         voice_row, step_column, step_active,      valid/ready
//                        velocity, accent
//   pixels    out        pixel_index, red, green, blue             valid/ready
//   cfg       in         cfg_index, cfg_data                       cfg_we, no wait
//
// One request is taken every clock cycle while cells.ready is high. A cell
// that is shown passes through the input register, and then the color and index
// logic (one 7 x 23 bit constant multiply per channel and three saturating
// adds) settles into the result register.
// Reset clears the configuration and both valid flags; no clearing pass.
// When pixels stalls, the result register holds and the input register fills;
// cells.ready drops only when both are full. Cells that are not shown leave
// the input register even during a stall.
module step_grid_led_color_compositor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sgc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sgc_pkg::CFG_DATA_W-1:0]      cfg_data,
    sgc_cell_if.sink                            cells,
    sgc_pixel_if.source                         pixels
);

    sgc_pkg::cfg_t    cfg;
    sgc_pkg::place_t  place;
    sgc_pkg::rgb_t    color;

    // Input register.
    logic             in_valid_reg;
    logic             in_valid_next;
    sgc_pkg::cell_t   in_cell_reg;

    // Result register.
    logic             out_valid_reg;
    logic             out_valid_next;
    sgc_pkg::pixel_t  out_pix_reg;

    logic             take;
    logic             out_free;
    logic             in_leave;
    logic             load_out;

    sgc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sgc_place u_place (
        .grid_cell (in_cell_reg),
        .cfg       (cfg),
        .place     (place)
    );

    sgc_shade u_shade (
        .grid_cell (in_cell_reg),
        .cfg       (cfg),
        .color     (color)
    );

    // The result register can take a new pixel when it is empty or being
    // drained this cycle. A cell that produces no pixel may always leave.
    always_comb
    begin
        out_free    = !out_valid_reg || pixels.ready;
        in_leave    = in_valid_reg && (!place.keep || out_free);
        load_out    = in_valid_reg && place.keep && out_free;
        cells.ready = !in_valid_reg || in_leave;
        take        = cells.valid && cells.ready;

        if (take)
            in_valid_next = 1'b1;
        else if (in_leave)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (load_out)
            out_valid_next = 1'b1;
        else if (pixels.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_cell_reg.voice_row   <= cells.voice_row;
            in_cell_reg.step_column <= cells.step_column;
            in_cell_reg.step_active <= cells.step_active;
            in_cell_reg.velocity    <= cells.velocity;
            in_cell_reg.accent      <= cells.accent;
        end
        if (load_out)
        begin
            out_pix_reg.pixel_index <= place.pixel_index;
            out_pix_reg.color       <= color;
        end
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.pixel_index = out_pix_reg.pixel_index;
    assign pixels.red         = out_pix_reg.color.red;
    assign pixels.green       = out_pix_reg.color.green;
    assign pixels.blue        = out_pix_reg.color.blue;

endmodule

// File: src/sgc_cfg_regs.sv
// Configuration register file of the compositor: eight write-only fields.
// Depends on sgc_pkg.
module sgc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sgc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sgc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output sgc_pkg::cfg_t                       cfg
);

    sgc_pkg::cfg_t cfg_reg;
    sgc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (sgc_pkg::cfg_reg_e'(cfg_index))
                sgc_pkg::REG_SELECTED_VOICE:    cfg_next.selected_voice    = cfg_data[1:0];
                sgc_pkg::REG_CURSOR_COLUMN:     cfg_next.cursor_column     = cfg_data;
                sgc_pkg::REG_PLAYHEAD_COLUMN:   cfg_next.playhead_column   = cfg_data;
                sgc_pkg::REG_TRANSPORT_RUNNING: cfg_next.transport_running = cfg_data[0];
                sgc_pkg::REG_MUTE_MASK:         cfg_next.mute_mask         = cfg_data;
                sgc_pkg::REG_SOLO_MASK:         cfg_next.solo_mask         = cfg_data;
                sgc_pkg::REG_SERPENTINE_ORDER:  cfg_next.serpentine_order  = cfg_data[0];
                sgc_pkg::REG_SINGLE_ROW_STRIP:  cfg_next.single_row_strip  = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/sgc_place.sv
// Strip placement of one grid cell: pixel index and whether the cell is shown.
// Depends on sgc_pkg.
module sgc_place (
    input  sgc_pkg::cell_t  grid_cell,
    input  sgc_pkg::cfg_t   cfg,
    output sgc_pkg::place_t place
);

    logic                        in_grid;
    logic [sgc_pkg::COL_W-1:0]   column;
    logic [7:0]                  index_full;

    always_comb
    begin
        in_grid = (int'(grid_cell.voice_row) < sgc_pkg::GRID_ROWS) &&
                  (int'(grid_cell.step_column) < sgc_pkg::GRID_COLUMNS);

        // Odd rows run backwards when the strip snakes through the grid.
        if (cfg.serpentine_order && grid_cell.voice_row[0])
            column = sgc_pkg::COL_W'(sgc_pkg::GRID_COLUMNS - 1) - grid_cell.step_column;
        else
            column = grid_cell.step_column;

        if (cfg.single_row_strip)
            index_full = 8'(grid_cell.step_column);
        else
            index_full = 8'(grid_cell.voice_row) * 8'(sgc_pkg::GRID_COLUMNS) + 8'(column);

        place.keep        = in_grid &&
                            (!cfg.single_row_strip ||
                             grid_cell.voice_row == cfg.selected_voice);
        place.pixel_index = index_full[sgc_pkg::INDEX_W-1:0];
    end

endmodule

// File: src/sgc_shade.sv
// Color of one grid cell: velocity scaling, ghosting, tints and saturating overlays.
// Depends on sgc_pkg.
module sgc_shade (
    input  sgc_pkg::cell_t  grid_cell,
    input  sgc_pkg::cfg_t   cfg,
    output sgc_pkg::rgb_t   color
);

    function automatic logic [sgc_pkg::CHAN_W-1:0] sat_add(
        input logic [sgc_pkg::CHAN_W-1:0] a,
        input logic [sgc_pkg::CHAN_W-1:0] b
    );
        logic [sgc_pkg::CHAN_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[sgc_pkg::CHAN_W] ? '1 : sum[sgc_pkg::CHAN_W-1:0];
    endfunction

    logic                          selected;
    logic                          silenced;
    logic                          beat;
    logic                          accent_on;
    logic                          cursor_on;
    logic                          playhead_on;
    logic [sgc_pkg::VEL_W-1:0]     level;
    logic [sgc_pkg::PROD_W-1:0]    prod   [3];
    logic [sgc_pkg::CHAN_W-1:0]    chan   [3];

    always_comb
    begin
        selected = (grid_cell.voice_row == cfg.selected_voice);
        // A row is silent when muted, or when some voice is soloed and this one is not.
        silenced = cfg.mute_mask[grid_cell.voice_row] ||
                   ((cfg.solo_mask != '0) && !cfg.solo_mask[grid_cell.voice_row]);

        if (grid_cell.step_active)
        begin
            if (silenced)
                level = sgc_pkg::GHOST_LEVEL;
            else if (grid_cell.velocity < sgc_pkg::VEL_FLOOR)
                level = sgc_pkg::VEL_FLOOR;
            else
                level = grid_cell.velocity;
        end
        else if (selected)
            level = sgc_pkg::TINT_LEVEL;
        else
            level = '0;

        beat        = !grid_cell.step_active && !selected &&
                      ((grid_cell.step_column & sgc_pkg::BEAT_MASK) == '0);
        accent_on   = grid_cell.step_active && grid_cell.accent && !silenced;
        cursor_on   = selected && (grid_cell.step_column == cfg.cursor_column);
        playhead_on = cfg.transport_running &&
                      (grid_cell.step_column == cfg.playhead_column);

        for (int k = 0; k < 3; k++)
        begin
            prod[k] = sgc_pkg::PROD_W'(level) *
                      sgc_pkg::PROD_W'(sgc_pkg::DIM_COEF[grid_cell.voice_row][k]);
            chan[k] = sgc_pkg::CHAN_W'(prod[k] >> sgc_pkg::DIM_SHIFT);
            if (beat)
                chan[k] = sgc_pkg::BEAT_LEVEL;
            if (accent_on)
                chan[k] = sat_add(chan[k], sgc_pkg::ACCENT_ADD);
            if (cursor_on)
                chan[k] = sat_add(chan[k], sgc_pkg::CURSOR_ADD);
            if (playhead_on)
                chan[k] = sat_add(chan[k], sgc_pkg::PLAYHEAD_ADD);
        end

        color.red   = chan[0];
        color.green = chan[1];
        color.blue  = chan[2];
    end

endmodule

// File: src/sgc_checker.sv
// Port-level checks for the compositor, attached to the top level by bind.
// Depends on sgc_pkg; the bind reads the members of the top level's channel ports.
module sgc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sgc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sgc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                cell_valid,
    input  logic                                cell_ready,
    input  logic                                pix_valid,
    input  logic                                pix_ready,
    input  logic [sgc_pkg::INDEX_W-1:0]         pix_index,
    input  logic [sgc_pkg::CHAN_W-1:0]          pix_red,
    input  logic [sgc_pkg::CHAN_W-1:0]          pix_green,
    input  logic [sgc_pkg::CHAN_W-1:0]          pix_blue
);

    // Tracks the single-row strip mode as written through the port.
    logic single_row_reg;
    logic single_row_next;

    always_comb
    begin
        single_row_next = single_row_reg;
        if (cfg_we && (cfg_index == sgc_pkg::REG_SINGLE_ROW_STRIP))
            single_row_next = cfg_data[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            single_row_reg <= 1'b0;
        else
            single_row_reg <= single_row_next;
    end

    // A stalled pixel stays offered.
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid)
        else $error("pixel withdrawn while stalled");

    // A stalled pixel keeps its contents.
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=>
            $stable(pix_index) && $stable(pix_red) &&
            $stable(pix_green) && $stable(pix_blue))
        else $error("stalled pixel changed");

    // A pixel appearing on an idle output traces back to a cell that was taken earlier.
    a_out_from_cell: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_valid) |-> $past(cell_valid && cell_ready, 2))
        else $error("pixel without a matching cell");

    // In single-row mode every pixel lies within one row of the strip.
    a_single_row_index: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && single_row_reg |-> int'(pix_index) < sgc_pkg::GRID_COLUMNS)
        else $error("pixel index outside the single row");

endmodule

bind step_grid_led_color_compositor sgc_checker u_sgc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cell_valid (cells.valid),
    .cell_ready (cells.ready),
    .pix_valid  (pixels.valid),
    .pix_ready  (pixels.ready),
    .pix_index  (pixels.pixel_index),
    .pix_red    (pixels.red),
    .pix_green  (pixels.green),
    .pix_blue   (pixels.blue)
);

// File: test/step_grid_led_color_compositor_tb.sv
// Self-checking testbench for the step-grid LED color compositor.
// Needs sgc_pkg and the sgc_cell_if / sgc_pixel_if interfaces from src; it predicts every
// pixel from the cell request and the current register settings and checks it in order.
module step_grid_led_color_compositor_tb;

    // Run control.
    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 5;
    localparam int TAIL_CYCLES     = 8;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int RANDOM_PHASES   = 12;
    localparam int SHOWN_PER_PHASE = 45;
    localparam int REPORT_LIMIT    = 10;

    // Color arithmetic of the LED grid.
    localparam int unsigned LED_BRIGHTNESS = 60;
    localparam int unsigned SCALE_DEN      = 127 * 255;
    localparam int unsigned FLOOR_VEL      = 24;
    localparam int unsigned GHOST_VEL      = 16;
    localparam int unsigned TINT_VEL       = 12;
    localparam int unsigned BEAT_GLOW      = 2;
    localparam int unsigned ACCENT_BOOST   = 40;
    localparam int unsigned CURSOR_BOOST   = 90;
    localparam int unsigned PLAYHEAD_BOOST = 60;
    localparam int unsigned CHAN_MAX       = 255;
    localparam int unsigned STRIP_COLUMNS  = 16;
    localparam int unsigned STRIP_ROWS     = 4;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [sgc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sgc_pkg::CFG_DATA_W-1:0]  cfg_data;

    sgc_cell_if  cells_ch ();
    sgc_pixel_if pixels_ch ();

    step_grid_led_color_compositor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cells     (cells_ch),
        .pixels    (pixels_ch)
    );

    always #CLK_HALF clk = ~clk;

    // Register settings as the block should currently hold them. They only change while
    // the block is idle, so every cell request is predicted when it is accepted.
    sgc_pkg::cfg_t   shadow_cfg;
    // Pixels still owed by the block, oldest first.
    sgc_pkg::pixel_t pending_pixels [$];
    int              mismatch_count = 0;
    int              shown_total    = 0;
    // Random idling on the request side and on the pixel side.
    bit              sender_gaps    = 1'b0;
    bit              sink_stalls    = 1'b0;

    function automatic int unsigned scale_channel(int unsigned base, int unsigned level);
        return (base * level * LED_BRIGHTNESS) / SCALE_DEN;
    endfunction

    function automatic int unsigned add_clamped(int unsigned a, int unsigned b);
        return (a + b > CHAN_MAX) ? CHAN_MAX : a + b;
    endfunction

    // Base color of each drum voice: red, orange, green, blue.
    function automatic int unsigned voice_base(logic [sgc_pkg::ROW_W-1:0] row, int ch);
        logic [23:0] rgb;
        case (row)
            2'd0:    rgb = {8'd255, 8'd0,   8'd0};
            2'd1:    rgb = {8'd255, 8'd140, 8'd0};
            2'd2:    rgb = {8'd0,   8'd255, 8'd0};
            default: rgb = {8'd0,   8'd80,  8'd255};
        endcase
        return rgb[23 - 8 * ch -: 8];
    endfunction

    // Works out the LED that a grid cell lights. Returns 0 when the cell is not shown.
    function automatic bit predict_pixel(input sgc_pkg::cell_t c, input sgc_pkg::cfg_t k,
                                         output sgc_pkg::pixel_t px);
        bit          selected;
        bit          silenced;
        int unsigned level;
        int unsigned strip_col;
        int unsigned chan [3];
        px = '0;
        selected = (c.voice_row == k.selected_voice);
        if (c.voice_row >= STRIP_ROWS || c.step_column >= STRIP_COLUMNS)
            return 1'b0;
        // Strip placement: one row alone, or the full grid with optional zigzag.
        if (k.single_row_strip)
        begin
            if (!selected)
                return 1'b0;
            px.pixel_index = sgc_pkg::INDEX_W'(c.step_column);
        end
        else
        begin
            strip_col = c.step_column;
            if (k.serpentine_order && c.voice_row[0])
                strip_col = STRIP_COLUMNS - 1 - c.step_column;
            px.pixel_index = sgc_pkg::INDEX_W'(c.voice_row * STRIP_COLUMNS + strip_col);
        end
        // A row is silenced when muted, or when some voice solos and this one does not.
        silenced = k.mute_mask[c.voice_row] || (k.solo_mask != 0 && !k.solo_mask[c.voice_row]);
        for (int ch = 0; ch < 3; ch++)
        begin
            if (c.step_active)
            begin
                level = (c.velocity < FLOOR_VEL) ? FLOOR_VEL : c.velocity;
                if (silenced)
                    level = GHOST_VEL;
                chan[ch] = scale_channel(voice_base(c.voice_row, ch), level);
                if (c.accent && !silenced)
                    chan[ch] = add_clamped(chan[ch], ACCENT_BOOST);
            end
            else if (selected)
                chan[ch] = scale_channel(voice_base(c.voice_row, ch), TINT_VEL);
            else if (c.step_column[1:0] == 2'b00)
                chan[ch] = BEAT_GLOW;
            else
                chan[ch] = 0;
            if (selected && c.step_column == k.cursor_column)
                chan[ch] = add_clamped(chan[ch], CURSOR_BOOST);
            if (k.transport_running && c.step_column == k.playhead_column)
                chan[ch] = add_clamped(chan[ch], PLAYHEAD_BOOST);
        end
        px.color.red   = sgc_pkg::CHAN_W'(chan[0]);
        px.color.green = sgc_pkg::CHAN_W'(chan[1]);
        px.color.blue  = sgc_pkg::CHAN_W'(chan[2]);
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic sgc_pkg::cell_t make_cell(logic [sgc_pkg::ROW_W-1:0] row,
                                                 logic [sgc_pkg::COL_W-1:0] col,
                                                 logic active,
                                                 logic [sgc_pkg::VEL_W-1:0] vel,
                                                 logic acc);
        sgc_pkg::cell_t c;
        c.voice_row   = row;
        c.step_column = col;
        c.step_active = active;
        c.velocity    = vel;
        c.accent      = acc;
        return c;
    endfunction

    // Offers one cell request and waits for the handshake. Valid stays high after the
    // handshake so that back-to-back requests need no second assignment in one step; it
    // drops only for an idle burst or when the sender waits for the block to drain.
    task automatic send_cell(input sgc_pkg::cell_t c);
        sgc_pkg::pixel_t px;
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            cells_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        cells_ch.valid       <= 1'b1;
        cells_ch.voice_row   <= c.voice_row;
        cells_ch.step_column <= c.step_column;
        cells_ch.step_active <= c.step_active;
        cells_ch.velocity    <= c.velocity;
        cells_ch.accent      <= c.accent;
        @(posedge clk);
        while (cells_ch.ready !== 1'b1)
            @(posedge clk);
        if (predict_pixel(c, shadow_cfg, px))
        begin
            pending_pixels.push_back(px);
            shown_total++;
        end
    endtask

    // Stops sending and waits until every owed pixel has come out, then lets the pipeline
    // run empty, since cells that light nothing may still be inside it.
    task automatic wait_drained();
        int waited;
        waited = 0;
        cells_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_pixels.size() != 0)
        begin
            note_mismatch($sformatf("%0d expected pixels never arrived",
                                    pending_pixels.size()));
            pending_pixels.delete();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // One register write; the write enable is lowered by the caller after the last one.
    task automatic put_reg(input sgc_pkg::cfg_reg_e r,
                           input logic [sgc_pkg::CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    // Writes the whole register set while the block is idle.
    task automatic apply_config(input sgc_pkg::cfg_t k);
        wait_drained();
        put_reg(sgc_pkg::REG_SELECTED_VOICE,    sgc_pkg::CFG_DATA_W'(k.selected_voice));
        put_reg(sgc_pkg::REG_CURSOR_COLUMN,     sgc_pkg::CFG_DATA_W'(k.cursor_column));
        put_reg(sgc_pkg::REG_PLAYHEAD_COLUMN,   sgc_pkg::CFG_DATA_W'(k.playhead_column));
        put_reg(sgc_pkg::REG_TRANSPORT_RUNNING, sgc_pkg::CFG_DATA_W'(k.transport_running));
        put_reg(sgc_pkg::REG_MUTE_MASK,         sgc_pkg::CFG_DATA_W'(k.mute_mask));
        put_reg(sgc_pkg::REG_SOLO_MASK,         sgc_pkg::CFG_DATA_W'(k.solo_mask));
        put_reg(sgc_pkg::REG_SERPENTINE_ORDER,  sgc_pkg::CFG_DATA_W'(k.serpentine_order));
        put_reg(sgc_pkg::REG_SINGLE_ROW_STRIP,  sgc_pkg::CFG_DATA_W'(k.single_row_strip));
        cfg_we <= 1'b0;
        shadow_cfg = k;
    endtask

    // Straight after reset all registers are zero: voice 0 selected, cursor on column 0,
    // transport stopped. Covers the velocity floor, full velocity with accent, the
    // cursor stacking on an accented hit, the selected-row tint, a beat marker and a dark cell.
    task automatic test_reset_colors();
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        send_cell(make_cell(2'd1, 4'd5,  1'b1, 7'd0,   1'b0));
        send_cell(make_cell(2'd1, 4'd6,  1'b1, 7'd23,  1'b0));
        send_cell(make_cell(2'd2, 4'd7,  1'b1, 7'd24,  1'b0));
        send_cell(make_cell(2'd3, 4'd9,  1'b1, 7'd127, 1'b1));
        send_cell(make_cell(2'd0, 4'd0,  1'b1, 7'd127, 1'b1));
        send_cell(make_cell(2'd2, 4'd8,  1'b0, 7'd127, 1'b1));
        send_cell(make_cell(2'd3, 4'd3,  1'b0, 7'd0,   1'b0));
        send_cell(make_cell(2'd0, 4'd5,  1'b0, 7'd64,  1'b0));
    endtask

    // Cursor and playhead on the last column, both stacking on an accented full hit.
    task automatic test_overlays();
        sgc_pkg::cfg_t k;
        k = '0;
        k.selected_voice    = 2'd2;
        k.cursor_column     = 4'd15;
        k.playhead_column   = 4'd15;
        k.transport_running = 1'b1;
        apply_config(k);
        send_cell(make_cell(2'd2, 4'd15, 1'b1, 7'd127, 1'b1));
        send_cell(make_cell(2'd1, 4'd15, 1'b0, 7'd0,   1'b0));
        send_cell(make_cell(2'd2, 4'd3,  1'b0, 7'd0,   1'b0));
        send_cell(make_cell(2'd0, 4'd4,  1'b0, 7'd0,   1'b0));
    endtask

    // A muted row shows ghost hits without accent; then a solo silences the other rows.
    task automatic test_silenced_rows();
        sgc_pkg::cfg_t k;
        k = '0;
        k.mute_mask = 4'b0010;
        apply_config(k);
        send_cell(make_cell(2'd1, 4'd6,  1'b1, 7'd100, 1'b1));
        send_cell(make_cell(2'd0, 4'd6,  1'b1, 7'd100, 1'b1));
        k.mute_mask = 4'b0000;
        k.solo_mask = 4'b1000;
        apply_config(k);
        send_cell(make_cell(2'd3, 4'd10, 1'b1, 7'd50,  1'b1));
        send_cell(make_cell(2'd2, 4'd11, 1'b1, 7'd127, 1'b1));
    endtask

    // Zigzag placement on odd rows, then single-row mode, which overrides the zigzag and
    // drops every cell that is not on the selected row.
    task automatic test_strip_layout();
        sgc_pkg::cfg_t k;
        k = '0;
        k.serpentine_order = 1'b1;
        apply_config(k);
        send_cell(make_cell(2'd1, 4'd0,  1'b1, 7'd80, 1'b0));
        send_cell(make_cell(2'd3, 4'd15, 1'b1, 7'd80, 1'b0));
        send_cell(make_cell(2'd2, 4'd3,  1'b1, 7'd80, 1'b0));
        k.selected_voice   = 2'd1;
        k.single_row_strip = 1'b1;
        apply_config(k);
        send_cell(make_cell(2'd1, 4'd2,  1'b1, 7'd80, 1'b0));
        send_cell(make_cell(2'd0, 4'd2,  1'b1, 7'd80, 1'b0));
        send_cell(make_cell(2'd3, 4'd15, 1'b1, 7'd80, 1'b0));
    endtask

    function automatic sgc_pkg::cfg_t random_cfg();
        sgc_pkg::cfg_t k;
        k = $bits(sgc_pkg::cfg_t)'($urandom);
        k.single_row_strip = ($urandom_range(0, 3) == 0);
        return k;
    endfunction

    // Random cell, leaning toward the cases that matter: the selected row when only that
    // row is shown, the cursor and playhead columns, and velocities around the floor.
    function automatic sgc_pkg::cell_t random_cell(input sgc_pkg::cfg_t k);
        sgc_pkg::cell_t c;
        c = $bits(sgc_pkg::cell_t)'($urandom);
        if (k.single_row_strip && $urandom_range(0, 1) == 1)
            c.voice_row = k.selected_voice;
        case ($urandom_range(0, 7))
            0:       c.velocity = '0;
            1:       c.velocity = sgc_pkg::VEL_W'(FLOOR_VEL - 1);
            2:       c.velocity = sgc_pkg::VEL_W'(FLOOR_VEL);
            3:       c.velocity = '1;
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0:
            begin
                c.voice_row   = k.selected_voice;
                c.step_column = k.cursor_column;
            end
            1:       c.step_column = k.playhead_column;
            default: ;
        endcase
        return c;
    endfunction

    // Random traffic in phases with a fresh register set each time; the first two phases
    // use all-zero and all-one settings. The last phases run without any idling, and one
    // phase holds the sender halfway until the block has delivered everything.
    task automatic test_random_traffic();
        sgc_pkg::cfg_t k;
        int            phase_start;
        bit            held;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                k = '0;
            else if (phase == 1)
                k = '1;
            else
                k = random_cfg();
            apply_config(k);
            sender_gaps = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            sink_stalls = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            phase_start = shown_total;
            held = 1'b0;
            while (shown_total - phase_start < SHOWN_PER_PHASE)
            begin
                send_cell(random_cell(k));
                if (phase == 3 && !held && shown_total - phase_start >= SHOWN_PER_PHASE / 2)
                begin
                    held = 1'b1;
                    wait_drained();
                end
            end
        end
    endtask

    // Pixel side: ready with random stall bursts while stalls are enabled.
    initial
    begin : pixel_sink
        pixels_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                pixels_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            pixels_ch.ready <= 1'b1;
        end
    end

    // Every accepted pixel must match the oldest owed one, field by field.
    always @(posedge clk)
    begin : pixel_checker
        sgc_pkg::pixel_t want;
        if (rst_n && pixels_ch.valid === 1'b1 && pixels_ch.ready === 1'b1)
        begin
            if (pending_pixels.size() == 0)
                note_mismatch($sformatf("unexpected pixel index %0d rgb %0d/%0d/%0d",
                                        pixels_ch.pixel_index, pixels_ch.red,
                                        pixels_ch.green, pixels_ch.blue));
            else
            begin
                want = pending_pixels.pop_front();
                if (pixels_ch.pixel_index !== want.pixel_index)
                    note_mismatch($sformatf("pixel_index expected %0d got %0d",
                                            want.pixel_index, pixels_ch.pixel_index));
                if (pixels_ch.red !== want.color.red)
                    note_mismatch($sformatf("red at index %0d expected %0d got %0d",
                                            want.pixel_index, want.color.red, pixels_ch.red));
                if (pixels_ch.green !== want.color.green)
                    note_mismatch($sformatf("green at index %0d expected %0d got %0d",
                                            want.pixel_index, want.color.green,
                                            pixels_ch.green));
                if (pixels_ch.blue !== want.color.blue)
                    note_mismatch($sformatf("blue at index %0d expected %0d got %0d",
                                            want.pixel_index, want.color.blue,
                                            pixels_ch.blue));
            end
        end
    end

    initial
    begin : run_limit
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : test_sequence
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= sgc_pkg::REG_SELECTED_VOICE;
        cfg_data             <= '0;
        cells_ch.valid       <= 1'b0;
        cells_ch.voice_row   <= '0;
        cells_ch.step_column <= '0;
        cells_ch.step_active <= 1'b0;
        cells_ch.velocity    <= '0;
        cells_ch.accent      <= 1'b0;
        shadow_cfg = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_colors();
        test_overlays();
        test_silenced_rows();
        test_strip_layout();
        test_random_traffic();
        wait_drained();

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
